// File: design/lptm_pkg.sv
// Shared widths, codes and defaults for the LRU page cache tag manager.
package lptm_pkg;

   localparam int PAGE_W        = 52;
   localparam int RANGE_W       = 32;
   localparam int SLOT_W        = 6;
   localparam int CFG_W         = 7;
   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_EVICT_BATCH = 16;
   localparam logic [CFG_W-1:0] PAGES_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_FLAGS  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_HIT            = 2'd0,
      ST_MISS           = 2'd1,
      ST_NOT_FOUND      = 2'd2,
      ST_NONE_EVICTABLE = 2'd3
   } status_type;

   typedef enum logic {
      KIND_STATUS    = 1'b0,
      KIND_WRITEBACK = 1'b1
   } kind_type;

endpackage

// File: design/lru_page_cache_tag_manager_top.sv
// Tag manager for a fully associative page cache with LRU order and batch eviction.
//
// Channels: req_* carries one operation (lookup, add, remove, set flags) per
// transfer; rsp_* returns its results, any writebacks first (LRU order) and a
// single status result last, marked by rsp_last. csr_* writes pages_in_use.
// All tag state lives in two single-port-write memories (tag/range and
// metadata) with registered reads; every operation is done by sweeps that
// read, modify and write back one slot per cycle.
// Steps: a lookup miss, a failed remove or a flag update takes one find
// sweep before the result. Hits, removes and inserts add one update sweep.
// An eviction adds a writeback step, an unlink sweep and a check per
// evicted entry, plus a final link sweep if a slot is then free.
// The sweep length over the metadata memory sets the item rate; one item is
// worked on at a time and req_ready is high only while the block is idle.
// Reset: synchronous; afterwards a clearing pass over every slot zeroes
// the metadata memory, during which no request is taken (csr writes are).
// A stalled rsp_ready holds the output register and pauses the sequencer
// before the next result; no result is lost or repeated.
module lru_page_cache_tag_manager_top
   import lptm_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int EVICT_BATCH = DEF_EVICT_BATCH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CFG_W-1:0]   csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [PAGE_W-1:0]  req_page_number,
   input  logic               req_is_dirty,
   input  logic [RANGE_W-1:0] req_range_id,
   input  logic               req_in_page_cache,
   input  logic               req_in_flash_cache,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [1:0]         rsp_status,
   output logic [PAGE_W-1:0]  rsp_page_out,
   output logic               rsp_dirty_out,
   output logic [RANGE_W-1:0] rsp_range_out,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic               rsp_last
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = ((IW + 1) > CFG_W) ? (IW + 1) : CFG_W;
   localparam int BW = $clog2(EVICT_BATCH + 1);

   typedef struct packed {
      logic          valid;
      logic          dirty;
      logic          pc;
      logic          fc;
      logic [IW-1:0] rank;
   } meta_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [RANGE_W-1:0] range;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FIND, S_DECIDE, S_SWEEP, S_WB, S_EVSWEEP, S_EVNEXT, S_FINAL
   } state_type;

   typedef enum logic [1:0] {
      M_NONE, M_TOUCH, M_UNLINK, M_LINK
   } mode_type;

   // memories
   meta_type  meta_mem [CAPACITY];
   entry_type entry_mem [CAPACITY];
   meta_type  meta_rd_ff;
   entry_type entry_rd_ff;

   state_type state_ff;
   mode_type  mode_ff;
   logic [CFG_W-1:0] pages_ff;
   logic [IW:0]      rd_cnt_ff;
   logic             p_vld_ff;
   logic [IW-1:0]    p_idx_ff;

   // request registers
   op_type             req_op_ff;
   logic [PAGE_W-1:0]  req_page_ff;
   logic               req_dirty_ff;
   logic [RANGE_W-1:0] req_range_ff;
   logic               req_pc_ff;
   logic               req_fc_ff;

   // sweep accumulators
   logic          hit_ff;
   logic [IW-1:0] hit_slot_ff;
   logic [IW-1:0] hit_rank_ff;
   logic          hit_dirty_ff;
   logic          free_ff;
   logic [IW-1:0] free_slot_ff;
   logic          ev_ff;
   logic [IW-1:0] ev_slot_ff;
   logic [IW-1:0] ev_rank_ff;
   logic          ev_dirty_ff;
   logic          ev_fc_ff;
   logic [PAGE_W-1:0]  ev_page_ff;
   logic [RANGE_W-1:0] ev_range_ff;

   // update parameters, evict count, final status
   logic [IW-1:0] upd_slot_ff;
   logic [IW-1:0] upd_rank_ff;
   logic [BW-1:0] ev_cnt_ff;
   status_type    fin_status_ff;
   logic          fin_dirty_ff;
   logic [IW-1:0] fin_slot_ff;

   // output register
   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff;
   status_type         rsp_status_ff;
   logic [PAGE_W-1:0]  rsp_page_ff;
   logic               rsp_dirty_ff;
   logic [RANGE_W-1:0] rsp_range_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic               rsp_last_ff;

   logic          sweeping;
   logic          issue;
   logic          sweep_done;
   logic [IW-1:0] rd_idx;
   logic          out_free;
   logic          need_wb;
   logic          rsp_load;
   meta_type      new_meta;
   logic          meta_we;
   logic [IW-1:0] meta_wa;
   meta_type      meta_wd;
   logic          entry_we;

   assign sweeping   = (state_ff == S_FIND) || (state_ff == S_SWEEP) ||
                       (state_ff == S_EVSWEEP);
   assign issue      = sweeping && (rd_cnt_ff < (IW+1)'(CAPACITY));
   assign rd_idx     = rd_cnt_ff[IW-1:0];
   assign sweep_done = p_vld_ff && (p_idx_ff == IW'(CAPACITY - 1));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign need_wb    = !ev_fc_ff || ev_dirty_ff;
   // output register takes a new result this cycle
   assign rsp_load   = out_free && (((state_ff == S_WB) && need_wb) ||
                                    (state_ff == S_FINAL));

   // per-slot modification during a sweep
   always_comb begin
      new_meta = meta_rd_ff;
      unique case (mode_ff)
         M_TOUCH: begin
            if (p_idx_ff == upd_slot_ff) begin
               new_meta.rank  = '0;
               new_meta.dirty = meta_rd_ff.dirty |
                                ((req_op_ff == OP_ADD) && req_dirty_ff);
            end else if (meta_rd_ff.valid && meta_rd_ff.rank < upd_rank_ff) begin
               new_meta.rank = meta_rd_ff.rank + 1'b1;
            end
         end
         M_UNLINK: begin
            if (p_idx_ff == upd_slot_ff) begin
               new_meta.valid = 1'b0;
               new_meta.dirty = 1'b0;
               new_meta.rank  = '0;
            end else if (meta_rd_ff.valid && meta_rd_ff.rank > upd_rank_ff) begin
               new_meta.rank = meta_rd_ff.rank - 1'b1;
            end
         end
         M_LINK: begin
            if (p_idx_ff == upd_slot_ff) begin
               new_meta.valid = 1'b1;
               new_meta.dirty = req_dirty_ff;
               new_meta.pc    = req_pc_ff;
               new_meta.fc    = req_fc_ff;
               new_meta.rank  = '0;
            end else if (meta_rd_ff.valid) begin
               new_meta.rank = meta_rd_ff.rank + 1'b1;
            end
         end
         default: begin
            new_meta = meta_rd_ff;
         end
      endcase
   end

   // metadata write port select
   always_comb begin
      meta_we = 1'b0;
      meta_wa = p_idx_ff;
      meta_wd = new_meta;
      if (state_ff == S_CLEAR) begin
         meta_we = 1'b1;
         meta_wa = rd_idx;
         meta_wd = '0;
      end else if (state_ff == S_DECIDE && req_op_ff == OP_FLAGS && hit_ff) begin
         meta_we = 1'b1;
         meta_wa = hit_slot_ff;
         meta_wd = '{valid: 1'b1, dirty: hit_dirty_ff, pc: req_pc_ff, fc: req_fc_ff,
                     rank: hit_rank_ff};
      end else if (sweeping && p_vld_ff) begin
         meta_we = 1'b1;
      end
   end

   assign entry_we = (state_ff == S_SWEEP) && (mode_ff == M_LINK) && p_vld_ff &&
                     (p_idx_ff == upd_slot_ff);

   // metadata memory
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_rd_ff <= meta_mem[rd_idx];
   end

   // tag and range memory
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[upd_slot_ff] <= '{page: req_page_ff, range: req_range_ff};
      end
      entry_rd_ff <= entry_mem[rd_idx];
   end

   // sequencer, sweep engine and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         mode_ff      <= M_NONE;
         pages_ff     <= PAGES_RESET;
         rd_cnt_ff    <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            pages_ff <= csr_data;
         end
         if (rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         // sweep address and pipeline
         p_vld_ff <= issue;
         p_idx_ff <= rd_idx;
         if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
         if (sweeping && rd_cnt_ff == '0) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            ev_ff   <= 1'b0;
         end

         // gather hit, lowest free slot and least recent evictable entry
         if (sweeping && p_vld_ff) begin
            if (new_meta.valid && entry_rd_ff.page == req_page_ff && !hit_ff) begin
               hit_ff       <= 1'b1;
               hit_slot_ff  <= p_idx_ff;
               hit_rank_ff  <= new_meta.rank;
               hit_dirty_ff <= new_meta.dirty;
            end
            if (!new_meta.valid && (CW'(p_idx_ff) < CW'(pages_ff)) && !free_ff) begin
               free_ff      <= 1'b1;
               free_slot_ff <= p_idx_ff;
            end
            if (new_meta.valid && !new_meta.pc &&
                (!ev_ff || new_meta.rank > ev_rank_ff)) begin
               ev_ff       <= 1'b1;
               ev_slot_ff  <= p_idx_ff;
               ev_rank_ff  <= new_meta.rank;
               ev_dirty_ff <= new_meta.dirty;
               ev_fc_ff    <= new_meta.fc;
               ev_page_ff  <= entry_rd_ff.page;
               ev_range_ff <= entry_rd_ff.range;
            end
         end
         if (sweep_done) begin
            rd_cnt_ff <= '0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               if (rd_idx == IW'(CAPACITY - 1)) begin
                  rd_cnt_ff <= '0;
                  state_ff  <= S_IDLE;
               end else begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_op_ff    <= op_type'(req_op);
                  req_page_ff  <= req_page_number;
                  req_dirty_ff <= req_is_dirty;
                  req_range_ff <= req_range_id;
                  req_pc_ff    <= req_in_page_cache;
                  req_fc_ff    <= req_in_flash_cache;
                  mode_ff      <= M_NONE;
                  state_ff     <= S_FIND;
               end
            end
            S_FIND: begin
               if (sweep_done) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               upd_rank_ff <= hit_rank_ff;
               case (req_op_ff) inside
                  OP_LOOKUP, OP_REMOVE, OP_FLAGS: begin
                     upd_slot_ff <= hit_slot_ff;
                     if (hit_ff) begin
                        fin_status_ff <= ST_HIT;
                        fin_dirty_ff  <= hit_dirty_ff;
                        fin_slot_ff   <= hit_slot_ff;
                        if (req_op_ff != OP_FLAGS) begin
                           mode_ff  <= (req_op_ff == OP_LOOKUP) ? M_TOUCH : M_UNLINK;
                           state_ff <= S_SWEEP;
                        end else begin
                           state_ff <= S_FINAL;
                        end
                     end else begin
                        fin_status_ff <= (req_op_ff == OP_LOOKUP) ? ST_MISS : ST_NOT_FOUND;
                        fin_dirty_ff  <= 1'b0;
                        fin_slot_ff   <= '0;
                        state_ff      <= S_FINAL;
                     end
                  end
                  default: begin
                     if (hit_ff) begin
                        fin_status_ff <= ST_HIT;
                        fin_dirty_ff  <= hit_dirty_ff | req_dirty_ff;
                        fin_slot_ff   <= hit_slot_ff;
                        upd_slot_ff   <= hit_slot_ff;
                        mode_ff       <= M_TOUCH;
                        state_ff      <= S_SWEEP;
                     end else if (free_ff) begin
                        fin_status_ff <= ST_MISS;
                        fin_dirty_ff  <= req_dirty_ff;
                        fin_slot_ff   <= free_slot_ff;
                        upd_slot_ff   <= free_slot_ff;
                        mode_ff       <= M_LINK;
                        state_ff      <= S_SWEEP;
                     end else if (ev_ff) begin
                        ev_cnt_ff <= '0;
                        state_ff  <= S_WB;
                     end else begin
                        fin_status_ff <= ST_NONE_EVICTABLE;
                        fin_dirty_ff  <= 1'b0;
                        fin_slot_ff   <= '0;
                        state_ff      <= S_FINAL;
                     end
                  end
               endcase
            end
            S_WB: begin
               if (!need_wb || out_free) begin
                  if (need_wb) begin
                     rsp_valid_ff  <= 1'b1;
                     rsp_kind_ff   <= KIND_WRITEBACK;
                     rsp_status_ff <= ST_HIT;
                     rsp_page_ff   <= ev_page_ff;
                     rsp_dirty_ff  <= ev_dirty_ff;
                     rsp_range_ff  <= ev_range_ff;
                     rsp_slot_ff   <= SLOT_W'(ev_slot_ff);
                     rsp_last_ff   <= 1'b0;
                  end
                  upd_slot_ff <= ev_slot_ff;
                  upd_rank_ff <= ev_rank_ff;
                  ev_cnt_ff   <= ev_cnt_ff + 1'b1;
                  mode_ff     <= M_UNLINK;
                  state_ff    <= S_EVSWEEP;
               end
            end
            S_EVSWEEP: begin
               if (sweep_done) begin
                  state_ff <= S_EVNEXT;
               end
            end
            S_EVNEXT: begin
               if (ev_ff && ev_cnt_ff < BW'(EVICT_BATCH)) begin
                  state_ff <= S_WB;
               end else if (free_ff) begin
                  fin_status_ff <= ST_MISS;
                  fin_dirty_ff  <= req_dirty_ff;
                  fin_slot_ff   <= free_slot_ff;
                  upd_slot_ff   <= free_slot_ff;
                  mode_ff       <= M_LINK;
                  state_ff      <= S_SWEEP;
               end else begin
                  fin_status_ff <= ST_NONE_EVICTABLE;
                  fin_dirty_ff  <= 1'b0;
                  fin_slot_ff   <= '0;
                  state_ff      <= S_FINAL;
               end
            end
            S_SWEEP: begin
               if (sweep_done) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= KIND_STATUS;
                  rsp_status_ff <= fin_status_ff;
                  rsp_page_ff   <= req_page_ff;
                  rsp_dirty_ff  <= fin_dirty_ff;
                  rsp_range_ff  <= '0;
                  rsp_slot_ff   <= SLOT_W'(fin_slot_ff);
                  rsp_last_ff   <= 1'b1;
                  mode_ff       <= M_NONE;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign csr_ready     = 1'b1;
   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_page_out  = rsp_page_ff;
   assign rsp_dirty_out = rsp_dirty_ff;
   assign rsp_range_out = rsp_range_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// File: verif/lru_page_cache_tag_manager_top_tb.sv
// Testbench for the LRU page cache tag manager: own tag model, scoreboard, random traffic.
module lru_page_cache_tag_manager_top_tb;
   import lptm_pkg::*;

   localparam int NSLOT      = DEF_CAPACITY;
   localparam int BATCH      = DEF_EVICT_BATCH;
   localparam int CYCLE_CAP  = 1500000;
   localparam int NPAGES     = 100;

   typedef struct {
      op_type             op;
      logic [PAGE_W-1:0]  page;
      logic               dirty;
      logic [RANGE_W-1:0] rid;
      logic               pc;
      logic               fc;
   } page_req_t;

   typedef struct {
      kind_type           kind;
      status_type         status;
      logic [PAGE_W-1:0]  page;
      logic               dirty;
      logic [RANGE_W-1:0] rid;
      logic [SLOT_W-1:0]  slot;
      logic               last;
   } page_rsp_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = '0;
   logic [PAGE_W-1:0]  req_page_number = '0;
   logic               req_is_dirty = 1'b0;
   logic [RANGE_W-1:0] req_range_id = '0;
   logic               req_in_page_cache = 1'b0;
   logic               req_in_flash_cache = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_kind;
   logic [1:0]         rsp_status;
   logic [PAGE_W-1:0]  rsp_page_out;
   logic               rsp_dirty_out;
   logic [RANGE_W-1:0] rsp_range_out;
   logic [SLOT_W-1:0]  rsp_slot;
   logic               rsp_last;

   lru_page_cache_tag_manager_top dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_page_number(req_page_number), .req_is_dirty(req_is_dirty),
      .req_range_id(req_range_id), .req_in_page_cache(req_in_page_cache),
      .req_in_flash_cache(req_in_flash_cache),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_status(rsp_status), .rsp_page_out(rsp_page_out),
      .rsp_dirty_out(rsp_dirty_out), .rsp_range_out(rsp_range_out),
      .rsp_slot(rsp_slot), .rsp_last(rsp_last)
   );

   always #10 clock = ~clock;

   // tag model state
   logic [PAGE_W-1:0]  tag_mem [NSLOT];
   logic [RANGE_W-1:0] rid_mem [NSLOT];
   logic               used    [NSLOT];
   logic               dirty_m [NSLOT];
   logic               pc_m    [NSLOT];
   logic               fc_m    [NSLOT];
   int                 age     [NSLOT];
   int                 pages_cfg = PAGES_RESET;

   page_req_t  pending_reqs[$];
   page_rsp_t  expected_rsps[$];
   logic [PAGE_W-1:0] page_pool[NPAGES];

   int  snd_idle = 14;
   int  rcv_idle = 79;
   int  hold_left = 0;
   bit  hold_go = 0;
   bit  req_took = 0;
   bit  csr_took = 0;
   int  mismatches = 0;
   int  cycles = 0;

   function automatic int lowest_free_slot();
      int en;
      en = (pages_cfg > NSLOT) ? NSLOT : pages_cfg;
      for (int i = 0; i < en; i++)
         if (!used[i]) return i;
      return -1;
   endfunction

   task automatic expect_rsp(kind_type k, status_type st, logic [PAGE_W-1:0] pg, logic d,
                             logic [RANGE_W-1:0] rid, int s, logic lst);
      page_rsp_t r;
      r.kind = k; r.status = st; r.page = pg; r.dirty = d; r.rid = rid;
      r.slot = s[SLOT_W-1:0]; r.last = lst;
      expected_rsps.push_back(r);
   endtask

   // make a slot the most recent one
   task automatic promote(int s);
      int r;
      r = age[s];
      for (int i = 0; i < NSLOT; i++)
         if (used[i] && age[i] < r) age[i]++;
      age[s] = 0;
   endtask

   task automatic drop_slot(int s);
      int r;
      r = age[s];
      used[s] = 0;
      dirty_m[s] = 0;
      for (int i = 0; i < NSLOT; i++)
         if (used[i] && age[i] > r) age[i]--;
      age[s] = 0;
   endtask

   // works out the results of one accepted request and updates the tag model
   task automatic predict_tags(op_type op, logic [PAGE_W-1:0] pg, logic d,
                               logic [RANGE_W-1:0] rid, logic pc, logic fc);
      int s, n, rk;
      logic od;
      int victims[$];
      s = -1;
      for (int i = 0; i < NSLOT; i++)
         if (s < 0 && used[i] && tag_mem[i] == pg) s = i;
      case (op)
         OP_LOOKUP: begin
            if (s < 0) expect_rsp(KIND_STATUS, ST_MISS, pg, 0, 0, 0, 1);
            else begin
               promote(s);
               expect_rsp(KIND_STATUS, ST_HIT, pg, dirty_m[s], 0, s, 1);
            end
         end
         OP_REMOVE, OP_FLAGS: begin
            if (s < 0) expect_rsp(KIND_STATUS, ST_NOT_FOUND, pg, 0, 0, 0, 1);
            else begin
               od = dirty_m[s];
               if (op == OP_REMOVE) drop_slot(s);
               else begin
                  pc_m[s] = pc;
                  fc_m[s] = fc;
               end
               expect_rsp(KIND_STATUS, ST_HIT, pg, od, 0, s, 1);
            end
         end
         default: begin
            if (s >= 0) begin
               if (d) dirty_m[s] = 1;
               promote(s);
               expect_rsp(KIND_STATUS, ST_HIT, pg, dirty_m[s], 0, s, 1);
               return;
            end
            s = lowest_free_slot();
            if (s < 0) begin
               // batch eviction from the least recent end, skipping pinned pages
               n = 0;
               for (int i = 0; i < NSLOT; i++) if (used[i]) n++;
               for (rk = n; rk > 0 && victims.size() < BATCH; rk--)
                  for (int i = 0; i < NSLOT; i++)
                     if (used[i] && age[i] == rk - 1) begin
                        if (!pc_m[i]) victims.push_back(i);
                        break;
                     end
               if (victims.size() == 0) begin
                  expect_rsp(KIND_STATUS, ST_NONE_EVICTABLE, pg, 0, 0, 0, 1);
                  return;
               end
               foreach (victims[j]) begin
                  if (!fc_m[victims[j]] || dirty_m[victims[j]])
                     expect_rsp(KIND_WRITEBACK, ST_HIT, tag_mem[victims[j]],
                                dirty_m[victims[j]], rid_mem[victims[j]], victims[j], 0);
                  drop_slot(victims[j]);
               end
               s = lowest_free_slot();
               if (s < 0) begin
                  expect_rsp(KIND_STATUS, ST_NONE_EVICTABLE, pg, 0, 0, 0, 1);
                  return;
               end
            end
            tag_mem[s] = pg; rid_mem[s] = rid; dirty_m[s] = d; pc_m[s] = pc; fc_m[s] = fc;
            for (int i = 0; i < NSLOT; i++) if (used[i]) age[i]++;
            used[s] = 1;
            age[s] = 0;
            expect_rsp(KIND_STATUS, ST_MISS, pg, d, 0, s, 1);
         end
      endcase
   endtask

   // acceptance of transfers, scoreboard and watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            pages_cfg = csr_data;
            csr_took = 1;
         end
         if (req_valid && req_ready) begin
            predict_tags(op_type'(req_op), req_page_number, req_is_dirty, req_range_id,
                         req_in_page_cache, req_in_flash_cache);
            req_took = 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: page %h slot %0d", rsp_page_out, rsp_slot);
            end else begin
               page_rsp_t e;
               e = expected_rsps.pop_front();
               if (rsp_kind !== e.kind || rsp_status !== e.status || rsp_page_out !== e.page
                   || rsp_dirty_out !== e.dirty || rsp_range_out !== e.rid
                   || rsp_slot !== e.slot || rsp_last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp k%0d st%0d pg %h d%0d r %h s%0d l%0d",
                              e.kind, e.status, e.page, e.dirty, e.rid, e.slot, e.last);
                     $display("          got k%0d st%0d pg %h d%0d r %h s%0d l%0d",
                              rsp_kind, rsp_status, rsp_page_out, rsp_dirty_out,
                              rsp_range_out, rsp_slot, rsp_last);
                  end
               end
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) req_valid <= 1'b0;
      else if (!req_valid || req_took) begin
         if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle) begin
            page_req_t p;
            p = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_op <= p.op;
            req_page_number <= p.page;
            req_is_dirty <= p.dirty;
            req_range_id <= p.rid;
            req_in_page_cache <= p.pc;
            req_in_flash_cache <= p.fc;
         end else
            req_valid <= 1'b0;
      end
      req_took = 0;
   end

   // result receiver, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (hold_go) begin
         hold_go = 0;
         hold_left = 400;
         rsp_ready <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
   end

   task automatic queue_req(op_type op, logic [PAGE_W-1:0] pg, logic d,
                            logic [RANGE_W-1:0] rid, logic pc, logic fc);
      page_req_t p;
      p.op = op; p.page = pg; p.dirty = d; p.rid = rid; p.pc = pc; p.fc = fc;
      pending_reqs.push_back(p);
   endtask

   task automatic queue_random(int n);
      int sel;
      op_type op;
      repeat (n) begin
         sel = $urandom_range(99);
         op = (sel < 45) ? OP_ADD : (sel < 70) ? OP_LOOKUP : (sel < 80) ? OP_REMOVE : OP_FLAGS;
         queue_req(op, page_pool[$urandom_range(NPAGES-1)], $urandom_range(1),
                   $urandom, $urandom_range(99) < 30, $urandom_range(1));
      end
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // register write while the block is idle
   task automatic write_pages(int val);
      drain();
      @(negedge clock);
      csr_took = 0;
      csr_valid <= 1'b1;
      csr_data <= val[CFG_W-1:0];
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   initial begin
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < NPAGES; i++) page_pool[i] = PAGE_W'({$urandom, $urandom});
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: four slots, hits, misses, eviction, everything pinned
      write_pages(4);
      queue_req(OP_LOOKUP, page_pool[1], 0, 0, 0, 0);
      queue_req(OP_ADD, page_pool[0], 1, '1, 0, 1);
      queue_req(OP_ADD, page_pool[1], 0, 0, 0, 0);
      queue_req(OP_LOOKUP, page_pool[0], 0, 0, 0, 0);
      queue_req(OP_ADD, page_pool[0], 0, 0, 1, 1);
      queue_req(OP_REMOVE, page_pool[1], 0, 0, 0, 0);
      queue_req(OP_REMOVE, page_pool[1], 0, 0, 0, 0);
      queue_req(OP_FLAGS, page_pool[1], 0, 0, 1, 1);
      queue_req(OP_ADD, page_pool[2], 0, 32'h5a5a_a5a5, 0, 1);
      queue_req(OP_ADD, page_pool[3], 1, 32'h0000_0001, 1, 1);
      queue_req(OP_ADD, page_pool[4], 0, 32'h8000_0000, 0, 0);
      queue_req(OP_ADD, page_pool[5], 1, 32'h1234_5678, 0, 0);
      queue_req(OP_FLAGS, page_pool[3], 1, 0, 1, 0);
      queue_req(OP_ADD, page_pool[6], 0, 32'hdead_beef, 1, 0);
      queue_req(OP_ADD, page_pool[7], 1, '1, 1, 1);
      queue_req(OP_FLAGS, page_pool[5], 0, 0, 1, 1);
      queue_req(OP_ADD, page_pool[8], 1, 0, 0, 0);
      queue_req(OP_LOOKUP, page_pool[7], 0, 0, 0, 0);
      queue_req(OP_FLAGS, page_pool[6], 0, 0, 0, 1);
      queue_req(OP_ADD, page_pool[9], 0, 7, 0, 1);

      // above capacity
      write_pages(127);
      queue_random(110);

      snd_idle = 79; rcv_idle = 14;
      write_pages(8);
      queue_random(90);
      // no slot enabled: every add of a page not already cached has to fail
      write_pages(0);
      queue_random(15);

      snd_idle = 0; rcv_idle = 0;
      write_pages(1);
      queue_random(30);
      write_pages(64);
      hold_go = 1;
      queue_random(110);

      drain();
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
